### hdl/adtsp_pkg.sv
`default_nettype none

package adtsp_pkg;

    // Parser modes.
    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_SKIP   = 2'd2,
        MODE_EXPECT = 2'd3
    } parse_mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_SYNC  = 2'd1,
        STATUS_BAD_LAYER = 2'd2,
        STATUS_SHORT     = 2'd3
    } status_t;

    localparam logic [7:0]  SYNC_BYTE       = 8'hFF;
    localparam logic [7:0]  SYNC_NIBBLE     = 8'hF0;
    localparam logic [7:0]  LAYER_MASK      = 8'h06;
    localparam logic [3:0]  HDR_LEN_NO_CRC  = 4'd7;
    localparam logic [3:0]  HDR_LEN_CRC     = 4'd9;
    localparam logic [12:0] LAST_HDR_INDEX  = 13'd8;
    localparam logic [12:0] LEN_BYTE_INDEX  = 13'd5;
    localparam int          TDATA_WIDTH     = 88;

    // One decoded header or error report.
    typedef struct packed {
        status_t     status;
        logic [31:0] frame_start;
        logic        mpeg2_id;
        logic        crc_absent;
        logic [1:0]  profile;
        logic [3:0]  sampling_index;
        logic        private_bit;
        logic [2:0]  channel_config;
        logic [12:0] frame_length;
        logic [10:0] buffer_fullness;
        logic [1:0]  raw_blocks;
        logic [15:0] crc_word;
    } adtsp_result_t;

endpackage

`default_nettype wire

### hdl/adtsp_parser.sv
`default_nettype none

module adtsp_parser (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      step,
    input  wire [7:0]                data_byte,
    output logic                     res_valid,
    output adtsp_pkg::adtsp_result_t res
);

    adtsp_pkg::parse_mode_t mode_reg, mode_next;
    logic [12:0] bif_reg, bif_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] start_reg, start_next;
    logic [12:0] flen_reg, flen_next;
    logic [7:0]  hdr_reg [1:7];

    logic        hdr_we;
    logic [7:0]  hv [1:7];
    logic [3:0]  hlen;
    logic        fail;
    adtsp_pkg::status_t fail_code;
    logic        do_begin;

    // Header bytes as seen this cycle, with the incoming byte in its slot.
    always_comb
    begin
        for (int i = 1; i <= 7; i++)
        begin
            hv[i] = (bif_reg == 13'(i)) ? data_byte : hdr_reg[i];
        end
        hlen = hv[1][0] ? adtsp_pkg::HDR_LEN_NO_CRC : adtsp_pkg::HDR_LEN_CRC;
    end

    // Next state and result for one byte.
    always_comb
    begin
        mode_next  = mode_reg;
        bif_next   = bif_reg;
        pos_next   = pos_reg + 32'd1;
        start_next = start_reg;
        flen_next  = flen_reg;
        hdr_we     = 1'b0;
        fail       = 1'b0;
        fail_code  = adtsp_pkg::STATUS_OK;
        do_begin   = 1'b0;
        res_valid  = 1'b0;
        res        = '0;

        case (mode_reg)
            adtsp_pkg::MODE_HUNT:
            begin
                do_begin = (data_byte == adtsp_pkg::SYNC_BYTE);
            end
            adtsp_pkg::MODE_EXPECT:
            begin
                if (data_byte == adtsp_pkg::SYNC_BYTE)
                begin
                    do_begin = 1'b1;
                end
                else
                begin
                    res_valid       = 1'b1;
                    res.status      = adtsp_pkg::STATUS_BAD_SYNC;
                    res.frame_start = pos_reg;
                    mode_next       = adtsp_pkg::MODE_HUNT;
                end
            end
            adtsp_pkg::MODE_SKIP:
            begin
                bif_next = bif_reg + 13'd1;
                if (bif_next >= flen_reg)
                begin
                    mode_next = adtsp_pkg::MODE_EXPECT;
                end
            end
            default:
            begin
                if (bif_reg == 13'd0 || bif_reg > adtsp_pkg::LAST_HDR_INDEX)
                begin
                    do_begin = 1'b1;
                end
                else
                begin
                    // Sync nibble and layer check on the second byte.
                    if (bif_reg == 13'd1)
                    begin
                        if ((data_byte & adtsp_pkg::SYNC_NIBBLE) != adtsp_pkg::SYNC_NIBBLE)
                        begin
                            fail      = 1'b1;
                            fail_code = adtsp_pkg::STATUS_BAD_SYNC;
                        end
                        else if ((data_byte & adtsp_pkg::LAYER_MASK) != 8'd0)
                        begin
                            fail      = 1'b1;
                            fail_code = adtsp_pkg::STATUS_BAD_LAYER;
                        end
                    end
                    if (!fail)
                    begin
                        hdr_we   = (bif_reg < adtsp_pkg::LAST_HDR_INDEX);
                        bif_next = bif_reg + 13'd1;
                        if (bif_reg == adtsp_pkg::LEN_BYTE_INDEX)
                        begin
                            flen_next = {hv[3][1:0], hv[4], data_byte[7:5]};
                            if (flen_next < {9'd0, hlen})
                            begin
                                fail      = 1'b1;
                                fail_code = adtsp_pkg::STATUS_SHORT;
                            end
                        end
                    end
                    if (fail)
                    begin
                        res_valid       = 1'b1;
                        res.status      = fail_code;
                        res.frame_start = start_reg;
                        if (data_byte == adtsp_pkg::SYNC_BYTE)
                        begin
                            do_begin = 1'b1;
                        end
                        else
                        begin
                            mode_next = adtsp_pkg::MODE_HUNT;
                        end
                    end
                    else if (bif_next == {9'd0, hlen})
                    begin
                        // Last header byte: report the whole header.
                        res_valid           = 1'b1;
                        res.status          = adtsp_pkg::STATUS_OK;
                        res.frame_start     = start_reg;
                        res.mpeg2_id        = hv[1][3];
                        res.crc_absent      = hv[1][0];
                        res.profile         = hv[2][7:6];
                        res.sampling_index  = hv[2][5:2];
                        res.private_bit     = hv[2][1];
                        res.channel_config  = {hv[2][0], hv[3][7:6]};
                        res.frame_length    = flen_reg;
                        res.buffer_fullness = {hv[5][4:0], hv[6][7:2]};
                        res.raw_blocks      = hv[6][1:0];
                        res.crc_word        = hv[1][0] ? 16'd0 : {hv[7], data_byte};
                        mode_next = (flen_reg <= {9'd0, hlen}) ?
                                    adtsp_pkg::MODE_EXPECT : adtsp_pkg::MODE_SKIP;
                    end
                end
            end
        endcase

        // Open a new candidate frame at this byte.
        if (do_begin)
        begin
            start_next = pos_reg;
            bif_next   = 13'd1;
            flen_next  = 13'd0;
            mode_next  = adtsp_pkg::MODE_HEADER;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= adtsp_pkg::MODE_HUNT;
            bif_reg   <= 13'd0;
            pos_reg   <= 32'd0;
            start_reg <= 32'd0;
            flen_reg  <= 13'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            bif_reg   <= bif_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            flen_reg  <= flen_next;
        end
    end

    // Header byte store.
    always_ff @(posedge clk)
    begin
        if (step && hdr_we)
        begin
            hdr_reg[bif_reg[2:0]] <= data_byte;
        end
    end

`ifndef SYNTH
    // While collecting a header, the byte index stays within the longest header.
    a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == adtsp_pkg::MODE_HEADER |->
            (bif_reg >= 13'd1 && bif_reg <= adtsp_pkg::LAST_HDR_INDEX))
        else $error("header index out of range");

    // The frame length is known once the sixth header byte has passed.
    a_len_known: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == adtsp_pkg::MODE_HEADER && bif_reg > 13'd5) |->
            flen_reg >= {9'd0, adtsp_pkg::HDR_LEN_NO_CRC})
        else $error("frame length missing after length byte");

    // Skipping never runs past the frame end.
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == adtsp_pkg::MODE_SKIP |-> bif_reg < flen_reg)
        else $error("skip count beyond frame length");
`endif

endmodule

`default_nettype wire

### hdl/adts_frame_header_parser.sv
`default_nettype none

// ADTS header parser: takes an AAC ADTS byte stream one byte per word and
// sustains one byte per clock while no result is stalled; each byte passes
// an input register, combinational header decode, and a result register,
// which drives the result word. A result is given for each
// good header (on its last header byte, seven or nine bytes in) and for each
// sync, layer or short-length failure; payload bytes give none. Only a
// stalled result register holds back the input, since decode cannot advance
// without a free result slot.
module adts_frame_header_parser (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,  // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [31:0] frame_start, [32] mpeg2_id, [33] crc_absent, [35:34] profile,
    // [39:36] sampling_index, [40] private_bit, [43:41] channel_config,
    // [56:44] frame_length, [67:57] buffer_fullness, [69:68] raw_blocks,
    // [85:70] crc_word, [87:86] zero
    output logic [adtsp_pkg::TDATA_WIDTH-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser   // [1:0] status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    adtsp_pkg::adtsp_result_t out_reg;

    logic        step;
    logic        res_valid;
    adtsp_pkg::adtsp_result_t res;

    // Decode advances when a byte waits and the result slot is free or draining.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    adtsp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Pack the result word.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {2'b00,
                            out_reg.crc_word,
                            out_reg.raw_blocks,
                            out_reg.buffer_fullness,
                            out_reg.frame_length,
                            out_reg.channel_config,
                            out_reg.private_bit,
                            out_reg.sampling_index,
                            out_reg.profile,
                            out_reg.crc_absent,
                            out_reg.mpeg2_id,
                            out_reg.frame_start};

`ifndef SYNTH
    // A stalled result blocks decode.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !step)
        else $error("decode advanced over a stalled result");

    // Error results carry nothing beyond status and frame start.
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != adtsp_pkg::STATUS_OK) |->
            m_axis_tdata[adtsp_pkg::TDATA_WIDTH-1:32] == '0)
        else $error("error result with header fields set");

    // A good header is at least as long as its own header.
    a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == adtsp_pkg::STATUS_OK) |->
            (out_reg.frame_length >= {9'd0, adtsp_pkg::HDR_LEN_NO_CRC} &&
             (out_reg.crc_absent || out_reg.frame_length >= {9'd0, adtsp_pkg::HDR_LEN_CRC})))
        else $error("good header with short frame length");
`endif

endmodule

`default_nettype wire

### tb/adts_frame_header_parser_test.sv
`timescale 1ns / 1ps

module adts_frame_header_parser_test;

    import adtsp_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    // Ways in which a generated frame can be broken.
    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC,
        FLAW_LAYER,
        FLAW_CUT,
        FLAW_SHORT,
        FLAW_NO_PAYLOAD
    } frame_flaw_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata = 8'h00;
    logic m_axis_tready = 1'b0;
    wire s_axis_tready;
    wire m_axis_tvalid;
    wire [TDATA_WIDTH-1:0] m_axis_tdata;
    wire [1:0] m_axis_tuser;

    // Run control shared between the stimulus and the receiver.
    int idle_pct = 0;
    int stall_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    int failures = 0;
    int quiet_cycles = 0;

    // Parser state as the stream has been seen so far.
    parse_mode_t mode;
    logic [12:0] in_frame;
    logic [7:0] hdr [0:8];
    logic [31:0] stream_pos;
    logic [31:0] start_pos;
    logic [12:0] frame_len;

    adtsp_result_t pending_headers [$];

    adts_frame_header_parser u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Stream tracking
    function automatic void clear_stream_state();
        mode = MODE_HUNT;
        in_frame = '0;
        for (int i = 0; i < 9; i++)
        begin
            hdr[i] = 8'h00;
        end
        stream_pos = '0;
        start_pos = '0;
        frame_len = '0;
    endfunction

    function automatic void open_frame(input logic [31:0] pos, input logic [7:0] b);
        start_pos = pos;
        hdr[0] = b;
        in_frame = 13'd1;
        frame_len = '0;
        mode = MODE_HEADER;
    endfunction

    // Queue an error report, then resync: a sync byte opens a new frame at once.
    function automatic void fail_frame(input status_t code, input logic [31:0] where,
                                       input logic [31:0] pos, input logic [7:0] b);
        adtsp_result_t r;
        r = '0;
        r.status = code;
        r.frame_start = where;
        pending_headers.push_back(r);
        if (b == SYNC_BYTE)
            open_frame(pos, b);
        else
            mode = MODE_HUNT;
    endfunction

    function automatic void track_stream_byte(input logic [7:0] b);
        logic [31:0] pos;
        int idx;
        int hlen;
        bit bad;
        adtsp_result_t r;
        pos = stream_pos;
        stream_pos = pos + 32'd1;
        bad = 1'b0;
        case (mode)
            MODE_HUNT:
            begin
                if (b == SYNC_BYTE)
                    open_frame(pos, b);
            end
            MODE_EXPECT:
            begin
                if (b == SYNC_BYTE)
                    open_frame(pos, b);
                else
                    fail_frame(STATUS_BAD_SYNC, pos, pos, b);
            end
            MODE_SKIP:
            begin
                in_frame = in_frame + 13'd1;
                if (in_frame >= frame_len)
                    mode = MODE_EXPECT;
            end
            default:
            begin
                idx = int'(in_frame);
                if (idx == 0 || idx > 8)
                begin
                    open_frame(pos, b);
                end
                else
                begin
                    // The second byte carries the low sync nibble and the layer bits.
                    if (idx == 1)
                    begin
                        if ((b & SYNC_NIBBLE) != SYNC_NIBBLE)
                        begin
                            fail_frame(STATUS_BAD_SYNC, start_pos, pos, b);
                            bad = 1'b1;
                        end
                        else if ((b & LAYER_MASK) != 8'h00)
                        begin
                            fail_frame(STATUS_BAD_LAYER, start_pos, pos, b);
                            bad = 1'b1;
                        end
                    end
                    if (!bad)
                    begin
                        hdr[idx] = b;
                        in_frame = 13'(idx + 1);
                        hlen = hdr[1][0] ? int'(HDR_LEN_NO_CRC) : int'(HDR_LEN_CRC);
                        if (idx == LEN_BYTE_INDEX)
                        begin
                            frame_len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
                            if (frame_len < hlen)
                            begin
                                fail_frame(STATUS_SHORT, start_pos, pos, b);
                                bad = 1'b1;
                            end
                        end
                        if (!bad && idx + 1 == hlen)
                        begin
                            r = '0;
                            r.status = STATUS_OK;
                            r.frame_start = start_pos;
                            r.mpeg2_id = hdr[1][3];
                            r.crc_absent = hdr[1][0];
                            r.profile = hdr[2][7:6];
                            r.sampling_index = hdr[2][5:2];
                            r.private_bit = hdr[2][1];
                            r.channel_config = {hdr[2][0], hdr[3][7:6]};
                            r.frame_length = frame_len;
                            r.buffer_fullness = {hdr[5][4:0], hdr[6][7:2]};
                            r.raw_blocks = hdr[6][1:0];
                            r.crc_word = (hlen == HDR_LEN_CRC) ? {hdr[7], hdr[8]} : 16'h0000;
                            pending_headers.push_back(r);
                            mode = (frame_len <= hlen) ? MODE_EXPECT : MODE_SKIP;
                        end
                    end
                end
            end
        endcase
    endfunction

    // Stimulus helpers
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_stream_byte(b);
        bytes_sent++;
    endtask

    // Stop offering words until every queued result has come out.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_headers.size() != 0);
    endtask

    // One frame with random header fields; for an unflawed frame the payload fills out the length field.
    task automatic send_frame(input frame_flaw_t flaw, input bit no_crc,
                              input logic [12:0] len);
        logic [7:0] hb [0:8];
        int hlen;
        int nhdr;
        logic [10:0] fullness;
        logic [2:0] chan;
        hlen = no_crc ? int'(HDR_LEN_NO_CRC) : int'(HDR_LEN_CRC);
        fullness = 11'($urandom);
        chan = 3'($urandom);
        hb[0] = SYNC_BYTE;
        hb[1] = {4'hF, 1'($urandom), 2'b00, no_crc};
        hb[2] = {2'($urandom), 4'($urandom), 1'($urandom), chan[2]};
        hb[3] = {chan[1:0], 4'($urandom), len[12:11]};
        hb[4] = len[10:3];
        hb[5] = {len[2:0], fullness[10:6]};
        hb[6] = {fullness[5:0], 2'($urandom)};
        hb[7] = 8'($urandom);
        hb[8] = 8'($urandom);
        nhdr = hlen;
        case (flaw)
            FLAW_SYNC: hb[1][7:4] = 4'($urandom_range(0, 14));
            FLAW_LAYER: hb[1][2:1] = 2'($urandom_range(1, 3));
            FLAW_CUT: nhdr = $urandom_range(1, hlen - 1);
            default: ;
        endcase
        for (int i = 0; i < nhdr; i++)
        begin
            send_byte(hb[i]);
        end
        if (flaw == FLAW_NONE && len > hlen)
        begin
            for (int i = hlen; i < len; i++)
            begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Tests
    task automatic test_directed();
        logic [7:0] seq [0:25] = '{
            // MPEG-2, no CRC, every field at its top value, length seven
            8'hFF, 8'hF9, 8'hFF, 8'hFC, 8'h00, 8'hFF, 8'hFF,
            // MPEG-4 with CRC, zero fields, length nine, CRC word all ones
            8'hFF, 8'hF0, 8'h00, 8'h00, 8'h01, 8'h20, 8'h00, 8'hFF, 8'hFF,
            // no sync byte where the next frame must open
            8'h00,
            // second byte without the sync nibble
            8'hFF, 8'h0F,
            // layer bits set on a sync byte, which then opens a new frame
            8'hFF, 8'hFF,
            // that frame carries a zero length and is rejected as too short
            8'hF1, 8'h00, 8'h00, 8'h00, 8'h00
        };
        idle_pct = 0;
        stall_pct = 0;
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
        wait_for_results();
    endtask

    task automatic test_random_stream(input int n_bytes, input int idle, input int stall);
        int first;
        int pick;
        bit no_crc;
        int hlen;
        idle_pct = idle;
        stall_pct = stall;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
        begin
            no_crc = 1'($urandom);
            hlen = no_crc ? int'(HDR_LEN_NO_CRC) : int'(HDR_LEN_CRC);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                send_frame(FLAW_NONE, no_crc, 13'($urandom_range(hlen, 30)));
            else if (pick < 80)
                send_frame(FLAW_NONE, no_crc, 13'($urandom_range(hlen, 200)));
            else if (pick < 84)
                send_frame(FLAW_SYNC, no_crc, 13'($urandom_range(hlen, 30)));
            else if (pick < 88)
                send_frame(FLAW_LAYER, no_crc, 13'($urandom_range(hlen, 30)));
            else if (pick < 92)
                send_frame(FLAW_CUT, no_crc, 13'($urandom_range(hlen, 30)));
            else if (pick < 96)
                send_frame(FLAW_SHORT, no_crc, 13'($urandom_range(0, hlen - 1)));
            else
            begin
                // Loose bytes between frames.
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom));
            end
        end
        wait_for_results();
    endtask

    // The receiver holds off while minimum-length frames keep arriving.
    task automatic test_output_hold();
        idle_pct = 0;
        stall_pct = 0;
        holds_asked++;
        repeat (12)
            send_frame(FLAW_NONE, 1'b1, 13'(HDR_LEN_NO_CRC));
        wait_for_results();
    endtask

    // A header with the largest length field; the run ends inside its payload,
    // so the payload itself is left out.
    task automatic test_longest_frame();
        idle_pct = 0;
        stall_pct = 16;
        send_frame(FLAW_NO_PAYLOAD, 1'b0, 13'h1FFF);
        wait_for_results();
    endtask

    // Receiver: random stalls, plus a long hold whenever one is asked for.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each result word with the oldest expected header.
    always @(posedge clk)
    begin : result_check
        adtsp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_headers.size() == 0)
            begin
                $error("result word with no header pending: status %0d start 0x%0h",
                       m_axis_tuser, m_axis_tdata[31:0]);
                failures++;
            end
            else
            begin
                want = pending_headers.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("frame_start", want.frame_start, m_axis_tdata[31:0]);
                check_field("mpeg2_id", want.mpeg2_id, m_axis_tdata[32]);
                check_field("crc_absent", want.crc_absent, m_axis_tdata[33]);
                check_field("profile", want.profile, m_axis_tdata[35:34]);
                check_field("sampling_index", want.sampling_index, m_axis_tdata[39:36]);
                check_field("private_bit", want.private_bit, m_axis_tdata[40]);
                check_field("channel_config", want.channel_config, m_axis_tdata[43:41]);
                check_field("frame_length", want.frame_length, m_axis_tdata[56:44]);
                check_field("buffer_fullness", want.buffer_fullness, m_axis_tdata[67:57]);
                check_field("raw_blocks", want.raw_blocks, m_axis_tdata[69:68]);
                check_field("crc_word", want.crc_word, m_axis_tdata[85:70]);
            end
        end
    end

    // Watchdog: too long without a word moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clear_stream_state();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream(400, 0, 0);
        test_random_stream(400, 50, 0);
        test_output_hold();
        test_random_stream(400, 0, 50);
        test_random_stream(400, 16, 16);
        test_longest_frame();

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
